// ===== src/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, types and helpers shared by the quaternion vector rotation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    localparam int DW     = 32;
    localparam int UW     = DW + 1;
    localparam int PW     = 2 * UW;
    localparam int SUM_W  = PW + 2;
    localparam int H      = DW;
    localparam int HI_W   = SUM_W - H;
    localparam int PPL_W  = H + 1 + UW;
    localparam int PPH_W  = HI_W + UW;
    localparam int NUM_W  = SUM_W + UW + 3;
    localparam int QW     = DW + 2;
    localparam int NLANE  = 3;

    typedef logic signed [DW-1:0]    data_t;
    typedef logic signed [UW-1:0]    usig_t;
    typedef logic signed [PW-1:0]    prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [PPL_W-1:0] ppl_t;
    typedef logic signed [PPH_W-1:0] pph_t;
    typedef logic signed [NUM_W-1:0] snum_t;
    typedef logic [NUM_W-1:0]        num_t;
    typedef logic [QW-1:0]           quot_t;
    typedef logic [QW:0]             qmag_t;

    localparam qmag_t NEG_LIM  = {{(QW + 1 - DW){1'b0}}, 1'b1, {(DW - 1){1'b0}}};
    localparam qmag_t POS_LIM  = NEG_LIM - qmag_t'(1);
    localparam data_t DATA_MIN = {1'b1, {(DW - 1){1'b0}}};
    localparam data_t DATA_MAX = {1'b0, {(DW - 1){1'b1}}};

    typedef struct packed {
        logic                   zero;
        logic [NLANE-1:0]       neg;
        num_t [NLANE-1:0]       rem;
        quot_t [NLANE-1:0]      quot;
        num_t                   den;
    } div_stage_t;

    function automatic snum_t wide_term(input pph_t hi, input ppl_t lo);
        snum_t hs;
        snum_t ls;
        hs = NUM_W'(hi);
        hs = hs <<< H;
        ls = NUM_W'(lo);
        return hs + ls;
    endfunction

endpackage

`default_nettype wire

// ===== src/qvr_req_if.sv =====
// ----------------------------------------------------------------------------
// qvr_req_if
// Request channel: quaternion, vector and rotate or unrotate selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qvr_req_if
    import qvr_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  req_type;
    data_t quat_w;
    data_t quat_x;
    data_t quat_y;
    data_t quat_z;
    data_t vec_x;
    data_t vec_y;
    data_t vec_z;

    modport source (
        output valid, req_type, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, req_type, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/qvr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qvr_rsp_if
// Response channel: rotated vector and status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qvr_rsp_if
    import qvr_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t out_x;
    data_t out_y;
    data_t out_z;
    logic  zero_quat_error;
    logic  saturated;

    modport source (
        output valid, out_x, out_y, out_z, zero_quat_error, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, zero_quat_error, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/qvr_div.sv =====
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider, one quotient bit per stage for three lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_div
    import qvr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_vld,
    input  div_stage_t din,
    output logic       out_vld,
    output div_stage_t dout
);

    logic [QW:0]   vld;
    div_stage_t    st [QW+1];
    logic [QW-1:0] vld_reg;
    div_stage_t    st_reg [QW];

    assign vld[0] = in_vld;
    assign st[0]  = din;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        div_stage_t     st_next;
        logic [NUM_W:0] trial [NLANE];

        always_comb
        begin
            st_next = st[k];
            for (int l = 0; l < NLANE; l++)
            begin
                trial[l] = {1'b0, st[k].rem[l]} - {1'b0, st[k].den << (QW - 1 - k)};
                if (!trial[l][NUM_W])
                begin
                    st_next.rem[l] = trial[l][NUM_W-1:0];
                end
                st_next.quot[l] = {st[k].quot[l][QW-2:0], ~trial[l][NUM_W]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k] <= st_next;
            end
        end

        assign vld[k+1] = vld_reg[k];
        assign st[k+1]  = st_reg[k];
    end

    assign out_vld = vld[QW];
    assign dout    = st[QW];

endmodule

`default_nettype wire

// ===== src/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 vector by a quaternion of any length, or by its conjugate.
// Throughput: one transaction per cycle unless rsp.ready stalls the pipeline, set
// by the fully pipelined multipliers and the 34-stage divider, one quotient bit per stage.
// Reset: asynchronous active-low, clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qvr_req_if.sink   req,
    qvr_rsp_if.source rsp
);

    logic       adv;
    logic       out_vld_reg;
    logic [6:0] pre_vld_reg;
    logic       vld8_reg;

    // stage 1: operands, conjugate for unrotate
    usig_t w1_reg;
    usig_t u1_reg [NLANE];
    usig_t v1_reg [NLANE];
    usig_t u_in   [NLANE];

    // stage 2: products
    prod_t ww2_reg;
    prod_t sq2_reg  [NLANE];
    prod_t uv2_reg  [NLANE];
    prod_t cra2_reg [NLANE];
    prod_t crb2_reg [NLANE];
    usig_t w2_reg;
    usig_t u2_reg [NLANE];
    usig_t v2_reg [NLANE];

    // stage 3: sums
    sum_t  n3_reg;
    sum_t  s3_reg;
    sum_t  dot3_reg;
    sum_t  c3_reg [NLANE];
    usig_t w3_reg;
    usig_t u3_reg [NLANE];
    usig_t v3_reg [NLANE];

    // stage 4: partial products
    logic  zero4_reg;
    sum_t  n4_reg;
    ppl_t  sl4_reg [NLANE];
    pph_t  sh4_reg [NLANE];
    ppl_t  dl4_reg [NLANE];
    pph_t  dh4_reg [NLANE];
    ppl_t  cl4_reg [NLANE];
    pph_t  ch4_reg [NLANE];

    // stage 5: terms
    logic  zero5_reg;
    sum_t  n5_reg;
    snum_t a5_reg [NLANE];
    snum_t b5_reg [NLANE];
    snum_t c5_reg [NLANE];

    // stage 6: numerators
    logic  zero6_reg;
    sum_t  n6_reg;
    snum_t num6_reg [NLANE];

    // stage 7: magnitudes into the divider
    div_stage_t d7_reg;
    logic       dq_vld;
    div_stage_t dq;

    // stage 8: rounding
    logic             zero8_reg;
    logic [NLANE-1:0] neg8_reg;
    qmag_t            qm8_reg [NLANE];

    data_t            res [NLANE];
    logic [NLANE-1:0] sat;

    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
            vld8_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_vld_reg <= {pre_vld_reg[5:0], req.valid};
            vld8_reg    <= dq_vld;
            out_vld_reg <= vld8_reg;
        end
    end

    always_comb
    begin
        u_in[0] = UW'(req.quat_x);
        u_in[1] = UW'(req.quat_y);
        u_in[2] = UW'(req.quat_z);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            w1_reg    <= UW'(req.quat_w);
            v1_reg[0] <= UW'(req.vec_x);
            v1_reg[1] <= UW'(req.vec_y);
            v1_reg[2] <= UW'(req.vec_z);
            for (int l = 0; l < NLANE; l++)
            begin
                u1_reg[l] <= req.req_type ? -u_in[l] : u_in[l];
            end

            // stage 2
            ww2_reg     <= w1_reg * w1_reg;
            cra2_reg[0] <= u1_reg[1] * v1_reg[2];
            crb2_reg[0] <= u1_reg[2] * v1_reg[1];
            cra2_reg[1] <= u1_reg[2] * v1_reg[0];
            crb2_reg[1] <= u1_reg[0] * v1_reg[2];
            cra2_reg[2] <= u1_reg[0] * v1_reg[1];
            crb2_reg[2] <= u1_reg[1] * v1_reg[0];
            w2_reg      <= w1_reg;
            for (int l = 0; l < NLANE; l++)
            begin
                sq2_reg[l] <= u1_reg[l] * u1_reg[l];
                uv2_reg[l] <= u1_reg[l] * v1_reg[l];
                u2_reg[l]  <= u1_reg[l];
                v2_reg[l]  <= v1_reg[l];
            end

            // stage 3
            n3_reg   <= SUM_W'(ww2_reg) + SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1])
                        + SUM_W'(sq2_reg[2]);
            s3_reg   <= SUM_W'(ww2_reg) - SUM_W'(sq2_reg[0]) - SUM_W'(sq2_reg[1])
                        - SUM_W'(sq2_reg[2]);
            dot3_reg <= SUM_W'(uv2_reg[0]) + SUM_W'(uv2_reg[1]) + SUM_W'(uv2_reg[2]);
            w3_reg   <= w2_reg;
            for (int l = 0; l < NLANE; l++)
            begin
                c3_reg[l] <= SUM_W'(cra2_reg[l]) - SUM_W'(crb2_reg[l]);
                u3_reg[l] <= u2_reg[l];
                v3_reg[l] <= v2_reg[l];
            end

            // stage 4
            zero4_reg <= (n3_reg == '0);
            n4_reg    <= n3_reg;
            for (int l = 0; l < NLANE; l++)
            begin
                sl4_reg[l] <= $signed({1'b0, s3_reg[H-1:0]}) * v3_reg[l];
                sh4_reg[l] <= $signed(s3_reg[SUM_W-1:H]) * v3_reg[l];
                dl4_reg[l] <= $signed({1'b0, dot3_reg[H-1:0]}) * u3_reg[l];
                dh4_reg[l] <= $signed(dot3_reg[SUM_W-1:H]) * u3_reg[l];
                cl4_reg[l] <= $signed({1'b0, c3_reg[l][H-1:0]}) * w3_reg;
                ch4_reg[l] <= $signed(c3_reg[l][SUM_W-1:H]) * w3_reg;
            end

            // stage 5
            zero5_reg <= zero4_reg;
            n5_reg    <= n4_reg;
            for (int l = 0; l < NLANE; l++)
            begin
                a5_reg[l] <= wide_term(sh4_reg[l], sl4_reg[l]);
                b5_reg[l] <= wide_term(dh4_reg[l], dl4_reg[l]);
                c5_reg[l] <= wide_term(ch4_reg[l], cl4_reg[l]);
            end

            // stage 6
            zero6_reg <= zero5_reg;
            n6_reg    <= n5_reg;
            for (int l = 0; l < NLANE; l++)
            begin
                num6_reg[l] <= a5_reg[l] + ((b5_reg[l] + c5_reg[l]) <<< 1);
            end

            // stage 7
            d7_reg.zero <= zero6_reg;
            d7_reg.den  <= num_t'(n6_reg);
            for (int l = 0; l < NLANE; l++)
            begin
                d7_reg.neg[l]  <= num6_reg[l][NUM_W-1];
                d7_reg.rem[l]  <= num6_reg[l][NUM_W-1] ? num_t'(-num6_reg[l])
                                                       : num_t'(num6_reg[l]);
                d7_reg.quot[l] <= '0;
            end

            // stage 8: round half away from zero on the magnitude
            zero8_reg <= dq.zero;
            neg8_reg  <= dq.neg;
            for (int l = 0; l < NLANE; l++)
            begin
                qm8_reg[l] <= {1'b0, dq.quot[l]}
                              + qmag_t'({dq.rem[l][NUM_W-2:0], 1'b0} >= dq.den);
            end
        end
    end

    qvr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (pre_vld_reg[6]),
        .din     (d7_reg),
        .out_vld (dq_vld),
        .dout    (dq)
    );

    // saturation and zero quaternion override
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            if (zero8_reg)
            begin
                sat[l] = 1'b0;
                res[l] = '0;
            end
            else if (neg8_reg[l])
            begin
                sat[l] = (qm8_reg[l] > NEG_LIM);
                res[l] = sat[l] ? DATA_MIN : -data_t'(qm8_reg[l][DW-1:0]);
            end
            else
            begin
                sat[l] = (qm8_reg[l] > POS_LIM);
                res[l] = sat[l] ? DATA_MAX : data_t'(qm8_reg[l][DW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp.out_x           <= res[0];
            rsp.out_y           <= res[1];
            rsp.out_z           <= res[2];
            rsp.zero_quat_error <= zero8_reg;
            rsp.saturated       <= |sat;
        end
    end

    assign rsp.valid = out_vld_reg;

`ifndef SYNTHESIS
    a_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.zero_quat_error |->
        rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_z == '0 && !rsp.saturated)
        else $error("zero quaternion result not cleared");

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> pre_vld_reg[0])
        else $error("accepted transaction missing from first stage");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pre_vld_reg) && $stable(vld8_reg))
        else $error("pipeline moved while stalled");

    a_round_to_out : assert property (@(posedge clk) disable iff (!rst_n)
        vld8_reg && adv |=> rsp.valid)
        else $error("rounded transaction lost before output");
`endif

endmodule

`default_nettype wire
